>>> design/affine_2d_transform_compose_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform composer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_2D_TRANSFORM_COMPOSE_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_COMPOSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AFF2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aff2d check failed");

// Next-cycle implication, disabled during reset.
`define AFF2D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aff2d check failed");

`endif

>>> design/aff2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine transform composer package
// Fixed-point constants, the arctangent table and the pipeline stage record.
// ----------------------------------------------------------------------------
package aff2d_pkg;

    localparam int TRIG_BITS    = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int XW           = 34;
    localparam int ZW           = 34;
    localparam int CW           = TRIG_BITS + 3;

    localparam int QUARTER_UNITS = 5760;
    localparam int TURN_UNITS    = 23040;
    localparam int PI_DIV        = 292817;
    localparam int PI_REM        = 7586;
    localparam int HALF_DIV      = 5760;
    localparam int DIV45_RECIP   = 372827;
    localparam int DIV45_SHIFT   = 24;

    localparam logic signed [XW-1:0] KGAIN_Q30 = XW'(652032874);

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    typedef struct packed {
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    ox;
        logic signed [31:0]    oy;
        logic signed [15:0]    sx;
        logic signed [15:0]    sy;
        logic [1:0]            q;
        logic                  zero;
        logic [12:0]           r;
        logic [17:0]           n;
        logic [30:0]           rk;
        logic [17:0]           qe;
        logic signed [ZW-1:0]  z;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [CW-1:0]  c;
        logic signed [CW-1:0]  s;
        logic signed [31:0]    m00;
        logic signed [31:0]    m01;
        logic signed [31:0]    m10;
        logic signed [31:0]    m11;
        logic signed [63:0]    p00;
        logic signed [63:0]    p01;
        logic signed [63:0]    p10;
        logic signed [63:0]    p11;
        logic signed [31:0]    tx;
        logic signed [31:0]    ty;
    } stage_t;

endpackage

>>> design/affine_2d_transform_compose.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled;
// each CORDIC iteration has its own pipeline stage.
// Empty stages fill while the output is stalled, so input stalls only when all stages are full.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// Affine transform composer
// Builds the rotate, scale and translate matrix about a pivot in Q16.16.
// ----------------------------------------------------------------------------
module affine_2d_transform_compose
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] angle,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y
);

    localparam int CORDIC_FIRST = 4;
    localparam int ST_ROUND     = CORDIC_FIRST + aff2d_pkg::CORDIC_STEPS;
    localparam int ST_MAT       = ST_ROUND + 1;
    localparam int ST_PROD      = ST_MAT + 1;
    localparam int ST_SUM       = ST_PROD + 1;
    localparam int NSTG         = ST_SUM + 1;
    localparam int TB           = aff2d_pkg::TRIG_BITS;
    localparam int XW           = aff2d_pkg::XW;
    localparam int ZW           = aff2d_pkg::ZW;
    localparam int CW           = aff2d_pkg::CW;

    aff2d_pkg::stage_t st_reg  [NSTG];
    aff2d_pkg::stage_t st_next [NSTG];
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   rdy;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        logic signed [16:0] a;
        logic [17:0]        rem;
        logic [31:0]        zu;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [XW-1:0] xr;
        logic signed [XW-1:0] yr;
        logic signed [CW-1:0] cr;
        logic signed [CW-1:0] sr;
        logic signed [47:0] t00;
        logic signed [47:0] t01;
        logic signed [47:0] t10;
        logic signed [47:0] t11;
        logic signed [65:0] sx_sum;
        logic signed [65:0] sy_sum;
        logic signed [65:0] tx_w;
        logic signed [65:0] ty_w;

        st_next[0]    = '0;
        st_next[0].px = pos_x;
        st_next[0].py = pos_y;
        st_next[0].ox = pivot_x;
        st_next[0].oy = pivot_y;
        st_next[0].sx = scale_x;
        st_next[0].sy = scale_y;
        a = 17'(angle);
        if (a > 17'sd23040)
        begin
            a = 17'sd23040;
        end
        if (a < -17'sd23040)
        begin
            a = -17'sd23040;
        end
        if (a < 17'sd0)
        begin
            a = a + 17'(aff2d_pkg::TURN_UNITS);
        end
        if (a >= 17'(aff2d_pkg::TURN_UNITS))
        begin
            a = a - 17'(aff2d_pkg::TURN_UNITS);
        end
        priority if (a >= 17'(3 * aff2d_pkg::QUARTER_UNITS))
        begin
            st_next[0].q = 2'd3;
            st_next[0].r = 13'(a - 17'(3 * aff2d_pkg::QUARTER_UNITS));
        end
        else if (a >= 17'(2 * aff2d_pkg::QUARTER_UNITS))
        begin
            st_next[0].q = 2'd2;
            st_next[0].r = 13'(a - 17'(2 * aff2d_pkg::QUARTER_UNITS));
        end
        else if (a >= 17'(aff2d_pkg::QUARTER_UNITS))
        begin
            st_next[0].q = 2'd1;
            st_next[0].r = 13'(a - 17'(aff2d_pkg::QUARTER_UNITS));
        end
        else
        begin
            st_next[0].q = 2'd0;
            st_next[0].r = 13'(a);
        end
        st_next[0].zero = (st_next[0].r == 13'd0);

        for (int k = 1; k < NSTG; k++)
        begin
            st_next[k] = st_reg[k-1];
        end

        st_next[1].n  = 18'((32'(st_reg[0].r) * 32'(aff2d_pkg::PI_REM)
                            + 32'(aff2d_pkg::HALF_DIV)) >> 8);
        st_next[1].rk = 31'(32'(st_reg[0].r) * 32'(aff2d_pkg::PI_DIV));

        st_next[2].qe = 18'((40'(st_reg[1].n) * 40'(aff2d_pkg::DIV45_RECIP))
                            >> aff2d_pkg::DIV45_SHIFT);

        rem = st_reg[2].n - 18'(st_reg[2].qe * 18'd45);
        zu  = 32'(st_reg[2].rk) + 32'(st_reg[2].qe) + 32'(rem >= 18'd45);
        st_next[3].z = ZW'(signed'({2'b00, zu}));
        st_next[3].x = aff2d_pkg::KGAIN_Q30;
        st_next[3].y = '0;

        for (int k = CORDIC_FIRST; k < ST_ROUND; k++)
        begin
            dx = st_reg[k-1].y >>> (k - CORDIC_FIRST);
            dy = st_reg[k-1].x >>> (k - CORDIC_FIRST);
            if (!st_reg[k-1].z[ZW-1])
            begin
                st_next[k].x = st_reg[k-1].x - dx;
                st_next[k].y = st_reg[k-1].y + dy;
                st_next[k].z = st_reg[k-1].z
                             - ZW'(signed'({2'b00, aff2d_pkg::ATAN_Q30[k-CORDIC_FIRST]}));
            end
            else
            begin
                st_next[k].x = st_reg[k-1].x + dx;
                st_next[k].y = st_reg[k-1].y - dy;
                st_next[k].z = st_reg[k-1].z
                             + ZW'(signed'({2'b00, aff2d_pkg::ATAN_Q30[k-CORDIC_FIRST]}));
            end
        end

        xr = (st_reg[ST_ROUND-1].x + (XW'(1) <<< (29 - TB))) >>> (30 - TB);
        yr = (st_reg[ST_ROUND-1].y + (XW'(1) <<< (29 - TB))) >>> (30 - TB);
        if (st_reg[ST_ROUND-1].zero)
        begin
            cr = CW'(1) <<< TB;
            sr = '0;
        end
        else
        begin
            cr = CW'(xr);
            sr = CW'(yr);
        end
        unique case (st_reg[ST_ROUND-1].q)
            2'd1:
            begin
                st_next[ST_ROUND].c = -sr;
                st_next[ST_ROUND].s = cr;
            end
            2'd2:
            begin
                st_next[ST_ROUND].c = -cr;
                st_next[ST_ROUND].s = -sr;
            end
            2'd3:
            begin
                st_next[ST_ROUND].c = sr;
                st_next[ST_ROUND].s = -cr;
            end
            default:
            begin
                st_next[ST_ROUND].c = cr;
                st_next[ST_ROUND].s = sr;
            end
        endcase

        t00 = 48'(st_reg[ST_MAT-1].c) * 48'(st_reg[ST_MAT-1].sx);
        t01 = -(48'(st_reg[ST_MAT-1].s) * 48'(st_reg[ST_MAT-1].sy));
        t10 = 48'(st_reg[ST_MAT-1].s) * 48'(st_reg[ST_MAT-1].sx);
        t11 = 48'(st_reg[ST_MAT-1].c) * 48'(st_reg[ST_MAT-1].sy);
        st_next[ST_MAT].m00 = 32'((t00 + (48'sd1 <<< (TB - 9))) >>> (TB - 8));
        st_next[ST_MAT].m01 = 32'((t01 + (48'sd1 <<< (TB - 9))) >>> (TB - 8));
        st_next[ST_MAT].m10 = 32'((t10 + (48'sd1 <<< (TB - 9))) >>> (TB - 8));
        st_next[ST_MAT].m11 = 32'((t11 + (48'sd1 <<< (TB - 9))) >>> (TB - 8));

        st_next[ST_PROD].p00 = st_reg[ST_PROD-1].m00 * st_reg[ST_PROD-1].ox;
        st_next[ST_PROD].p01 = st_reg[ST_PROD-1].m01 * st_reg[ST_PROD-1].oy;
        st_next[ST_PROD].p10 = st_reg[ST_PROD-1].m10 * st_reg[ST_PROD-1].ox;
        st_next[ST_PROD].p11 = st_reg[ST_PROD-1].m11 * st_reg[ST_PROD-1].oy;

        sx_sum = (66'(st_reg[ST_SUM-1].p00) + 66'(st_reg[ST_SUM-1].p01) + 66'sd32768) >>> 16;
        sy_sum = (66'(st_reg[ST_SUM-1].p10) + 66'(st_reg[ST_SUM-1].p11) + 66'sd32768) >>> 16;
        tx_w = 66'(st_reg[ST_SUM-1].px) + 66'(st_reg[ST_SUM-1].ox) - sx_sum;
        ty_w = 66'(st_reg[ST_SUM-1].py) + 66'(st_reg[ST_SUM-1].oy) - sy_sum;
        priority if (tx_w > 66'sh7FFFFFFF)
        begin
            st_next[ST_SUM].tx = 32'sh7FFFFFFF;
        end
        else if (tx_w < -66'sh80000000)
        begin
            st_next[ST_SUM].tx = 32'sh80000000;
        end
        else
        begin
            st_next[ST_SUM].tx = 32'(tx_w);
        end
        priority if (ty_w > 66'sh7FFFFFFF)
        begin
            st_next[ST_SUM].ty = 32'sh7FFFFFFF;
        end
        else if (ty_w < -66'sh80000000)
        begin
            st_next[ST_SUM].ty = 32'sh80000000;
        end
        else
        begin
            st_next[ST_SUM].ty = 32'(ty_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign m00       = st_reg[NSTG-1].m00;
    assign m01       = st_reg[NSTG-1].m01;
    assign m10       = st_reg[NSTG-1].m10;
    assign m11       = st_reg[NSTG-1].m11;
    assign shift_x   = st_reg[NSTG-1].tx;
    assign shift_y   = st_reg[NSTG-1].ty;

endmodule

>>> design/aff2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine transform composer port checker
// Watches the handshake behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`include "affine_2d_transform_compose_assert.svh"

module aff2d_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] m00
);

    `AFF2D_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `AFF2D_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(m00))
    `AFF2D_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `AFF2D_ASSERT_NXT(a_stall_full, in_stall, out_valid)

endmodule

bind affine_2d_transform_compose aff2d_checker u_aff2d_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .m00       (m00)
);
